### hdl/rbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbh_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned RAD_BITS   = COORD_BITS - 1;
  localparam int unsigned ROOT_W     = 2 * RAD_BITS;
  localparam int unsigned NUM_W      = 2 * COORD_BITS - 1;

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Z  = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_INTENSITY = 2'd3
  } rbh_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic signed [COORD_BITS-1:0] vertex_height;
  } rbh_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] new_height;
    logic                         inside_brush;
    logic                         saturated;
  } rbh_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] height;
    logic                  in_brush;
  } rbh_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0]   rem;
    logic [RAD_BITS-1:0] root;
    rbh_side_t           side;
  } rbh_root_t;

  typedef struct packed {
    logic [NUM_W-1:0]      num;
    logic [COORD_BITS-1:0] rem;
    logic [COORD_BITS-1:0] quo;
    rbh_side_t             side;
  } rbh_quo_t;

endpackage

`default_nettype wire

### hdl/radial_falloff_height_brush_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Terrain brush: raises or lowers one grid vertex per word with a linear
// falloff around a configured center.
// Input channel: in_valid_i / in_stall_o carry a vertex word (x, z, height).
// Output channel: out_valid_o / out_stall_i carry the result word (new
// height, inside flag, saturation flag), one result per vertex, in order.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by
// cfg_idx_i (center x, center z, radius, intensity); write only while idle.
// The pipeline has three front stages (offset, square, compare), 31
// square-root cells (one root bit each), one multiply stage, 32 divider
// cells (one quotient bit each) and the output register.
// Throughput is one vertex per cycle; the cell chain moves every cycle the
// output register is empty or being taken.
// While the receiver stalls with a word waiting, the whole chain holds and
// in_stall_o is raised.
// Reset clears all valid bits and sets every configuration register to
// zero; a zero radius passes heights through unchanged.
module radial_falloff_height_brush_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  rbh_pkg::rbh_in_t     in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output rbh_pkg::rbh_out_t    out_word_o,
  input  wire                  cfg_we_i,
  input  rbh_pkg::rbh_reg_e    cfg_idx_i,
  input  wire [rbh_pkg::COORD_BITS-1:0] cfg_data_i
);
  import rbh_pkg::*;

  localparam int unsigned C = COORD_BITS;

  logic signed [C-1:0] cx_q, cz_q, int_q;
  logic [RAD_BITS-1:0] rad_q;
  logic [ROOT_W-1:0]   rad_sq_q;

  logic en;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cz_q  <= '0;
      rad_q <= '0;
      int_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X:  cx_q  <= cfg_data_i;
        REG_CENTER_Z:  cz_q  <= cfg_data_i;
        REG_RADIUS:    rad_q <= cfg_data_i[RAD_BITS-1:0];
        REG_INTENSITY: int_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rad_sq_q <= rad_q * rad_q;
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 0: offsets from center, magnitudes
  logic signed [C:0] dx, dz;
  logic [C:0]        adx_d, adz_d;
  logic [C:0]        adx_q, adz_q;
  logic [C-1:0]      h0_q;
  logic              v0_q;

  always_comb begin
    dx    = {in_word_i.vertex_x[C-1], in_word_i.vertex_x} - {cx_q[C-1], cx_q};
    dz    = {in_word_i.vertex_z[C-1], in_word_i.vertex_z} - {cz_q[C-1], cz_q};
    adx_d = dx[C] ? -dx : dx;
    adz_d = dz[C] ? -dz : dz;
  end

  // stage 1: squares
  logic [2*C+1:0] sqx_q, sqz_q;
  logic [C-1:0]   h1_q;
  logic           v1_q;

  // stage 2: sum and radius compare
  logic [2*C+2:0] d2;
  rbh_root_t      s2_q;
  logic           v2_q;

  assign d2 = {1'b0, sqx_q} + {1'b0, sqz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q              <= adx_d;
      adz_q              <= adz_d;
      h0_q               <= in_word_i.vertex_height;
      sqx_q              <= adx_q * adx_q;
      sqz_q              <= adz_q * adz_q;
      h1_q               <= h0_q;
      s2_q.rem           <= d2[ROOT_W-1:0];
      s2_q.root          <= '0;
      s2_q.side.height   <= h1_q;
      s2_q.side.in_brush <= (rad_q != '0) && (d2 <= (2*C+3)'(rad_sq_q));
    end
  end

  // square-root chain
  rbh_root_t root_s [0:RAD_BITS];
  logic      root_v [0:RAD_BITS];

  assign root_s[0] = s2_q;
  assign root_v[0] = v2_q;

  for (genvar k = 0; k < RAD_BITS; k++) begin : g_sqrt
    rbh_sqrt_cell #(.BIT(RAD_BITS - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (root_v[k]),
      .cell_i (root_s[k]),
      .vld_o  (root_v[k+1]),
      .cell_o (root_s[k+1])
    );
  end

  // multiply stage: |intensity| * (radius - distance)
  logic [C-1:0]        int_mag;
  logic [RAD_BITS-1:0] span;
  logic [NUM_W-1:0]    prod;
  rbh_quo_t            sm_q;
  logic                vm_q;

  always_comb begin
    int_mag = int_q[C-1] ? -int_q : int_q;
    span    = (root_s[RAD_BITS].root <= rad_q) ? rad_q - root_s[RAD_BITS].root : '0;
    prod    = int_mag * span;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= root_v[RAD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q.num  <= prod;
      sm_q.rem  <= C'(prod >> C);
      sm_q.quo  <= '0;
      sm_q.side <= root_s[RAD_BITS].side;
    end
  end

  // divider chain
  rbh_quo_t quo_s [0:C];
  logic     quo_v [0:C];

  assign quo_s[0] = sm_q;
  assign quo_v[0] = vm_q;

  for (genvar k = 0; k < C; k++) begin : g_div
    rbh_div_cell #(.BIT(C - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rad_i  (rad_q),
      .vld_i  (quo_v[k]),
      .cell_i (quo_s[k]),
      .vld_o  (quo_v[k+1]),
      .cell_o (quo_s[k+1])
    );
  end

  // output stage: add or subtract, clamp
  localparam logic signed [C+1:0] HI_LIM = (C+2)'((64'd1 << (C - 1)) - 64'd1);
  localparam logic signed [C+1:0] LO_LIM = -HI_LIM - (C+2)'(1);

  logic signed [C+1:0] hx, ax, sum;
  rbh_out_t            out_d, out_q;
  logic                vout_q;

  always_comb begin
    hx    = signed'({{2{quo_s[C].side.height[C-1]}}, quo_s[C].side.height});
    ax    = signed'({2'b00, quo_s[C].quo});
    sum   = int_q[C-1] ? hx - ax : hx + ax;
    out_d = '{new_height: quo_s[C].side.height, inside_brush: 1'b0, saturated: 1'b0};
    if (quo_s[C].side.in_brush) begin
      out_d.inside_brush = 1'b1;
      priority if (sum > HI_LIM) begin
        out_d.new_height = HI_LIM[C-1:0];
        out_d.saturated  = 1'b1;
      end else if (sum < LO_LIM) begin
        out_d.new_height = LO_LIM[C-1:0];
        out_d.saturated  = 1'b1;
      end else begin
        out_d.new_height = sum[C-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en) begin
      vout_q <= quo_v[C];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vout_q;
  assign out_word_o  = out_q;

  a_sat_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.saturated |-> out_word_o.inside_brush)
    else $error("saturated word outside brush");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_zero_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rad_q == '0) && $stable(rad_q) |-> !out_word_o.inside_brush)
    else $error("zero radius marked a vertex inside");

endmodule

`default_nettype wire

### hdl/rbh_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rbh_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire                 vld_i,
  input  rbh_pkg::rbh_root_t  cell_i,
  output logic                vld_o,
  output rbh_pkg::rbh_root_t  cell_o
);
  import rbh_pkg::*;

  logic [ROOT_W-1:0] term;
  rbh_root_t         cell_d;
  rbh_root_t         cell_q;
  logic              vld_q;

  // (t*t - r*r) for t = r | 2^BIT; r has no bits at or below BIT
  always_comb begin
    cell_d = cell_i;
    term   = (ROOT_W'(cell_i.root) << (BIT + 1)) | (ROOT_W'(1) << (2 * BIT));
    if (cell_i.rem >= term) begin
      cell_d.rem  = cell_i.rem - term;
      cell_d.root = cell_i.root | (RAD_BITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

`default_nettype wire

### hdl/rbh_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rbh_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            en_i,
  input  wire [rbh_pkg::RAD_BITS-1:0]    rad_i,
  input  wire                            vld_i,
  input  rbh_pkg::rbh_quo_t              cell_i,
  output logic                           vld_o,
  output rbh_pkg::rbh_quo_t              cell_o
);
  import rbh_pkg::*;

  logic [COORD_BITS-1:0] shifted;
  logic [COORD_BITS-1:0] rad_ext;
  rbh_quo_t              cell_d;
  rbh_quo_t              cell_q;
  logic                  vld_q;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    cell_d  = cell_i;
    rad_ext = {1'b0, rad_i};
    shifted = {cell_i.rem[COORD_BITS-2:0], cell_i.num[BIT]};
    if (shifted >= rad_ext) begin
      cell_d.rem = shifted - rad_ext;
      cell_d.quo = cell_i.quo | (COORD_BITS'(1) << BIT);
    end else begin
      cell_d.rem = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

`default_nettype wire
